>>> rtl/core/mdo_pkg.sv
`timescale 1ns / 1ps

package mdo_pkg;

	// Per-joint state depth. The joint field is three bits wide, so every
	// joint code selects its own entry.
	localparam int JOINTS = 8;
	localparam int JIDX_W = $clog2(JOINTS);
	localparam int JOINT_W = 3;
	localparam int DATA_W = 32;

	// Shared multiplier: signed operand times unsigned coefficient.
	localparam int MUL_A_W = 35;
	localparam int MUL_B_W = 20;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W + 1;
	localparam int WIDE_W = MUL_P_W + 1;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MALPHA = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BALPHA = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd4;

	localparam logic [16:0] ALPHA_ONE = 17'd65536;

	typedef logic signed [WIDE_W-1:0] wide_t;

	typedef struct packed {
		logic en;
		logic signed [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_req_t;

	localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

	function automatic logic signed [DATA_W-1:0] sat32(input wide_t v);
		logic signed [DATA_W-1:0] r;
		if (v > wide_t'(S32_MAX)) begin
			r = S32_MAX;
		end else if (v < wide_t'(S32_MIN)) begin
			r = S32_MIN;
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/core/mdo_mul.sv
`timescale 1ns / 1ps

// Shared multiplier with a registered product; the product holds until the
// next enabled request.
module mdo_mul (
	input  logic                                 clk,
	input  mdo_pkg::mul_req_t                    req,
	output logic signed [mdo_pkg::MUL_P_W-1:0]   prod
);

	logic signed [mdo_pkg::MUL_P_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= req.a * $signed({1'b0, req.b});
		end
	end

	assign prod = prod_q;

endmodule

>>> rtl/core/momentum_disturbance_observer_unit.sv
`timescale 1ns / 1ps

// Momentum disturbance observer for up to eight joints.
// Input stream (s_axis): one joint sample per transfer: joint index, measured
// momentum, nominal bias torque and applied torque, with tuser carrying the
// restart flag that reloads the joint's state from the momentum. The first
// sample seen for a joint after reset is treated as a restart.
// Output stream (m_axis): one result per input transfer, in order: joint
// index, clamped disturbance estimate, slow bias part and fast residual.
// Configuration: cfg_we writes cfg_data into the register chosen by
// cfg_index (gain, limit, momentum alpha, bias alpha, period). Writes are
// meant for idle periods only.
// Timing: a small sequencer walks each sample through one shared multiplier,
// five multiplications plus the adds between them. The result is loaded into
// the output register when the write-back step ends, and s_axis_tready
// returns high in the same cycle, so a new sample is taken only once the
// last one is written back. If the output register is still occupied
// because the receiver stalls, the sequencer holds its last step until the
// pending result is taken; the input side stays closed meanwhile.
// Reset: arst_n clears the sequencer, the output valid flag, the primed bits
// of all joints and restores the configuration defaults.
module momentum_disturbance_observer_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// [2:0] joint, [34:3] momentum, [66:35] bias_torque,
	// [98:67] applied_torque, [103:99] zero fill
	input  logic [103:0]  s_axis_tdata,
	// [0] restart
	input  logic          s_axis_tuser,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// [2:0] joint_out, [34:3] uncertainty, [66:35] slow_bias,
	// [98:67] fast_residual, [103:99] zero fill
	output logic [103:0]  m_axis_tdata,
	input  logic          cfg_we,
	input  logic [mdo_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]   cfg_data
);

	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] ST_IDLE = 4'd0;
	localparam logic [ST_W-1:0] ST_MFM  = 4'd1;
	localparam logic [ST_W-1:0] ST_FM   = 4'd2;
	localparam logic [ST_W-1:0] ST_DIF  = 4'd3;
	localparam logic [ST_W-1:0] ST_MG0  = 4'd4;
	localparam logic [ST_W-1:0] ST_MG1  = 4'd5;
	localparam logic [ST_W-1:0] ST_ACC  = 4'd6;
	localparam logic [ST_W-1:0] ST_CLP  = 4'd7;
	localparam logic [ST_W-1:0] ST_SUM  = 4'd8;
	localparam logic [ST_W-1:0] ST_MP   = 4'd9;
	localparam logic [ST_W-1:0] ST_IG   = 4'd10;
	localparam logic [ST_W-1:0] ST_MB   = 4'd11;
	localparam logic [ST_W-1:0] ST_BE   = 4'd12;
	localparam logic [ST_W-1:0] ST_WB   = 4'd13;

	localparam int DW = mdo_pkg::DATA_W;
	localparam int AW = mdo_pkg::MUL_A_W;
	localparam int PW = mdo_pkg::MUL_P_W;
	localparam int BW = mdo_pkg::MUL_B_W;
	localparam int JW = mdo_pkg::JIDX_W;
	localparam int MAG_W = 50;
	localparam int ACC_W = 34;

	localparam logic signed [PW-1:0] HALF16 = PW'(32768);
	localparam logic signed [PW-1:0] HALF20 = PW'(524288);

	// Configuration registers.
	logic [31:0] gain_q;
	logic [30:0] limit_q;
	logic [16:0] malpha_q;
	logic [15:0] balpha_q;
	logic [19:0] period_q;

	// Per-joint state; an entry is only read once its primed bit is set.
	logic signed [DW-1:0] fm_mem [mdo_pkg::JOINTS];
	logic signed [DW-1:0] ig_mem [mdo_pkg::JOINTS];
	logic signed [DW-1:0] be_mem [mdo_pkg::JOINTS];
	logic [mdo_pkg::JOINTS-1:0] primed_q;

	logic [ST_W-1:0] state_q;

	// Working registers of the item in flight.
	logic [mdo_pkg::JOINT_W-1:0] joint_q;
	logic signed [DW-1:0] fm_q;
	logic signed [DW-1:0] ig_q;
	logic signed [DW-1:0] be_q;
	logic signed [DW-1:0] u_q;
	logic signed [DW:0] tb_q;
	logic signed [AW-1:0] op_q;
	logic neg_q;
	logic [ACC_W-1:0] acc_q;
	logic [MAG_W-1:0] magsum_q;

	// Output register.
	logic out_valid_q;
	logic [mdo_pkg::JOINT_W-1:0] out_joint_q;
	logic signed [DW-1:0] out_u_q;
	logic signed [DW-1:0] out_slow_q;
	logic signed [DW-1:0] out_fast_q;

	// Input field decode.
	logic [mdo_pkg::JOINT_W-1:0] in_joint;
	logic signed [DW-1:0] in_mom;
	logic signed [DW-1:0] in_bias;
	logic signed [DW-1:0] in_app;
	logic [JW-1:0] in_jidx;
	logic [JW-1:0] jidx_q;
	logic in_xfer;
	logic in_init;
	logic signed [DW-1:0] fm_sel;
	logic out_free;

	mdo_pkg::mul_req_t mul_req;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] rnd16;
	logic signed [PW-1:0] rnd20;
	logic [16:0] ma_eff;
	logic signed [DW:0] dif;
	logic [30:0] magc;

	assign in_joint = s_axis_tdata[2:0];
	assign in_mom = s_axis_tdata[34:3];
	assign in_bias = s_axis_tdata[66:35];
	assign in_app = s_axis_tdata[98:67];
	assign in_jidx = in_joint[JW-1:0];
	assign jidx_q = joint_q[JW-1:0];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer = s_axis_tvalid && s_axis_tready;
	assign in_init = !primed_q[in_jidx] || s_axis_tuser;
	assign fm_sel = in_init ? in_mom : fm_mem[in_jidx];
	assign out_free = !out_valid_q || m_axis_tready;

	assign ma_eff = (malpha_q > mdo_pkg::ALPHA_ONE) ? mdo_pkg::ALPHA_ONE : malpha_q;

	// Round half toward plus infinity on the way down.
	assign rnd16 = (prod + HALF16) >>> 16;
	assign rnd20 = (prod + HALF20) >>> 20;

	assign dif = (DW + 1)'(fm_q) - (DW + 1)'(ig_q);
	assign magc = (magsum_q > MAG_W'(limit_q)) ? limit_q : magsum_q[30:0];

	// Coefficient selection for the shared multiplier.
	always_comb begin
		mul_req.a = op_q;
		mul_req.en = 1'b1;
		case (state_q)
			ST_MFM: mul_req.b = BW'(ma_eff);
			ST_MG0: mul_req.b = BW'(gain_q[15:0]);
			ST_MG1: mul_req.b = BW'(gain_q[31:16]);
			ST_MP: mul_req.b = period_q;
			ST_MB: mul_req.b = BW'(balpha_q);
			default: begin
				mul_req.b = '0;
				mul_req.en = 1'b0;
			end
		endcase
	end

	mdo_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= 32'd1966080;
			limit_q <= 31'd3276800;
			malpha_q <= 17'd65536;
			balpha_q <= 16'd0;
			period_q <= 20'd1049;
		end else if (cfg_we) begin
			case (cfg_index)
				mdo_pkg::REG_GAIN: gain_q <= cfg_data;
				mdo_pkg::REG_LIMIT: limit_q <= cfg_data[30:0];
				mdo_pkg::REG_MALPHA: malpha_q <= cfg_data[16:0];
				mdo_pkg::REG_BALPHA: balpha_q <= cfg_data[15:0];
				mdo_pkg::REG_PERIOD: period_q <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	// Sequencer, primed bits and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			primed_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result may replace the one leaving in the same cycle.
			if ((state_q == ST_WB) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_MFM;
					end
				end
				ST_WB: begin
					if (out_free) begin
						primed_q[jidx_q] <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= state_q + 4'd1;
			endcase
		end
	end

	// Datapath steps.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					joint_q <= in_joint;
					fm_q <= fm_sel;
					ig_q <= in_init ? in_mom : ig_mem[in_jidx];
					be_q <= in_init ? '0 : be_mem[in_jidx];
					op_q <= AW'(in_mom) - AW'(fm_sel);
					tb_q <= (DW + 1)'(in_bias) + (DW + 1)'(in_app);
				end
			end
			ST_FM: fm_q <= mdo_pkg::sat32(mdo_pkg::wide_t'(fm_q) + mdo_pkg::wide_t'(rnd16));
			ST_DIF: begin
				neg_q <= dif[DW];
				op_q <= dif[DW] ? -AW'(dif) : AW'(dif);
			end
			ST_MG1: acc_q <= rnd16[ACC_W-1:0];
			ST_ACC: magsum_q <= prod[MAG_W-1:0] + MAG_W'(acc_q);
			ST_CLP: u_q <= neg_q ? -$signed({1'b0, magc}) : $signed({1'b0, magc});
			ST_SUM: op_q <= AW'(tb_q) + AW'(u_q);
			ST_IG: begin
				ig_q <= mdo_pkg::sat32(mdo_pkg::wide_t'(ig_q) + mdo_pkg::wide_t'(rnd20));
				op_q <= AW'(u_q) - AW'(be_q);
			end
			ST_BE: begin
				if (balpha_q == 16'd0) begin
					be_q <= '0;
				end else begin
					be_q <= mdo_pkg::sat32(mdo_pkg::wide_t'(be_q) + mdo_pkg::wide_t'(rnd16));
				end
			end
			ST_WB: begin
				if (out_free) begin
					fm_mem[jidx_q] <= fm_q;
					ig_mem[jidx_q] <= ig_q;
					be_mem[jidx_q] <= be_q;
					out_joint_q <= joint_q;
					out_u_q <= u_q;
					out_slow_q <= be_q;
					out_fast_q <= mdo_pkg::sat32(mdo_pkg::wide_t'(u_q) - mdo_pkg::wide_t'(be_q));
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {5'b0, out_fast_q, out_slow_q, out_u_q, out_joint_q};

`ifndef SYNTHESIS
	// A result only appears from the write-back step.
	a_valid_from_wb: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_WB))
		else $error("result valid rose outside write-back");

	// The estimate never exceeds the configured clamp.
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((33'(out_u_q) <= $signed({2'b0, limit_q}))
			&& (33'(out_u_q) >= -$signed({2'b0, limit_q}))))
		else $error("uncertainty outside clamp");

	// With the bias split off, the slow part is zero and the fast part is the
	// whole estimate.
	a_split_off: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (balpha_q == 16'd0)) |->
			((out_slow_q == '0) && (out_fast_q == out_u_q)))
		else $error("bias split active while disabled");
`endif

endmodule
